FILE: rtl/ssat_pkg.sv
// Shared types and constants for the stereo square-root soft saturator.
// Holds fixed-point widths, register indexes, the config struct and the beat tag.
// No dependencies.
package ssat_pkg;

  // Register field widths
  localparam int unsigned GAIN_W = 19;
  localparam int unsigned SOAR_W = 15;
  localparam int unsigned WET_W  = 17;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_GAIN  = 2'd0,
    CFG_SOAR_OFFSET = 2'd1,
    CFG_OUTPUT_GAIN = 2'd2,
    CFG_WET_MIX     = 2'd3
  } cfg_idx_e;

  // Reset values
  localparam logic [GAIN_W-1:0] INPUT_GAIN_RST  = 19'd65536;
  localparam logic [SOAR_W-1:0] SOAR_OFFSET_RST = 15'd9830;
  localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST = 19'd65536;
  localparam logic [WET_W-1:0]  WET_MIX_RST     = 17'd65536;
  localparam logic [WET_W-1:0]  UNITY_Q16       = 17'd65536;

  // Datapath widths and alignments
  localparam int unsigned SQ_W       = 2 * SOAR_W;  // soar^2
  localparam int unsigned SQ_ALIGN   = 24;          // soar^2 to Q.56
  localparam int unsigned RAD_ALIGN  = 41;          // pre-gain product to Q.56 is RAD_ALIGN - W
  localparam int unsigned RAD_W      = 60;          // radicand in Q.56
  localparam int unsigned ROOT_W     = RAD_W / 2;   // root in Q.28
  localparam int unsigned SOAR_ALIGN = 12;          // soar Q.16 to Q.28
  localparam int unsigned PMUL_W     = ROOT_W + GAIN_W;
  localparam int unsigned P_DROP     = 8;           // Q.44 to Q.36
  localparam int unsigned P_W        = PMUL_W - P_DROP;
  localparam int unsigned DRY_ALIGN  = 37;          // dry magnitude to Q.36 is DRY_ALIGN - W
  localparam int unsigned DRY_W      = 37;
  localparam int unsigned WP_W       = P_W + WET_W;
  localparam int unsigned DP_W       = DRY_W + WET_W;
  localparam int unsigned MIX_W      = WP_W + 1;
  localparam int unsigned MIX_FRAC   = 53;          // mix to Q.(W-1) drops MIX_FRAC - W bits

  // Lane depth: three front stages, one root stage per result bit, four back stages
  localparam int unsigned LANE_LAT = 3 + ROOT_W + 4;

  // Register file seen by the lanes
  typedef struct packed {
    logic [GAIN_W-1:0] input_gain;
    logic [SOAR_W-1:0] soar_offset;
    logic [GAIN_W-1:0] output_gain;
    logic [WET_W-1:0]  wet_mix;
  } cfg_t;

  // Control carried alongside the lane data
  typedef struct packed {
    logic valid;
    logic last;
  } beat_tag_t;

endpackage

FILE: rtl/ssat_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Carries a sideband word through the same stages.
// Depends on ssat_pkg.
module ssat_sqrt #(
  parameter int unsigned SIDE_W = 25
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ssat_pkg::RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [ssat_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]           side_o
);
  import ssat_pkg::*;

  logic [ROOT_W+1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              fit;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fit ? (rem_sh - trial) : rem_sh;
        root_q[g] <= {root_in[ROOT_W-2:0], fit};
        rad_q[g]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[g] <= side_in;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

FILE: rtl/ssat_lane.sv
// One channel of the saturator: gain, square-root knee, post-gain, wet/dry mix,
// rounding and saturation, as a fixed-depth pipeline. Depends on ssat_pkg, ssat_sqrt.
module ssat_lane #(
  parameter int unsigned SAMPLE_W = 24
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  ssat_pkg::cfg_t             cfg_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SAMPLE_W-1:0] shaped_o
);
  import ssat_pkg::*;

  localparam int unsigned SideW    = SAMPLE_W + 1;
  localparam int unsigned ProdW    = SAMPLE_W + GAIN_W;
  localparam int unsigned AShift   = RAD_ALIGN - SAMPLE_W;
  localparam int unsigned DryShift = DRY_ALIGN - SAMPLE_W;
  localparam int unsigned RndShift = MIX_FRAC - SAMPLE_W;
  localparam int unsigned RndW     = MIX_W - RndShift;

  logic                neg0_q;
  logic [SAMPLE_W-1:0] mag0_q, mag0_d;
  logic [SideW-1:0]    side1_q, side2_q, side_sq, side3_q, side4_q, side5_q;
  logic [ProdW-1:0]    prod1_q;
  logic [SQ_W-1:0]     sq1_q;
  logic [RAD_W-1:0]    rad2_q, rad2_d;
  logic [ROOT_W-1:0]   root_sq, soar28;
  logic [ROOT_W-1:0]   shp3_q, shp3_d;
  logic [PMUL_W-1:0]   pmul;
  logic [P_W-1:0]      p4_q;
  logic [DRY_W-1:0]    dry;
  logic [WET_W-1:0]    dry_wt;
  logic [WP_W-1:0]     wp5_q, wp5_d;
  logic [DP_W-1:0]     dp5_q, dp5_d;
  logic [MIX_W-1:0]    mix, rnd;
  logic [RndW-1:0]     mag_r, limit, lim, mag_c;
  logic [SAMPLE_W-1:0] mag_w;
  logic                neg5;
  logic [SAMPLE_W-1:0] res6_q, res6_d;

  // Split the sample into sign and magnitude
  assign mag0_d = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;

  // Pre-gain product and soar squared
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg0_q  <= sample_i[SAMPLE_W-1];
      mag0_q  <= mag0_d;
      prod1_q <= ProdW'(mag0_q) * ProdW'(cfg_i.input_gain);
      sq1_q   <= SQ_W'(cfg_i.soar_offset) * SQ_W'(cfg_i.soar_offset);
      side1_q <= {neg0_q, mag0_q};
      rad2_q  <= rad2_d;
      side2_q <= side1_q;
    end
  end

  // Align both terms to Q.56 and add
  assign rad2_d = (RAD_W'(prod1_q) << AShift) + (RAD_W'(sq1_q) << SQ_ALIGN);

  ssat_sqrt #(
    .SIDE_W (SideW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (rad2_q),
    .side_i (side2_q),
    .root_o (root_sq),
    .side_o (side_sq)
  );

  // Subtract the knee offset, clamp at zero
  assign soar28 = ROOT_W'(cfg_i.soar_offset) << SOAR_ALIGN;
  assign shp3_d = (root_sq > soar28) ? (root_sq - soar28) : '0;

  // Post-gain, truncated to Q.36
  assign pmul = PMUL_W'(shp3_q) * PMUL_W'(cfg_i.output_gain);

  // Wet and dry products
  assign dry    = DRY_W'(side4_q[SAMPLE_W-1:0]) << DryShift;
  assign dry_wt = UNITY_Q16 - cfg_i.wet_mix;
  assign wp5_d  = WP_W'(p4_q) * WP_W'(cfg_i.wet_mix);
  assign dp5_d  = DP_W'(dry) * DP_W'(dry_wt);

  // Mix, round half up, saturate and restore the sign
  assign neg5  = side5_q[SAMPLE_W];
  assign mix   = MIX_W'(wp5_q) + MIX_W'(dp5_q);
  assign rnd   = mix + (MIX_W'(1) << (RndShift - 1));
  assign mag_r = rnd[MIX_W-1:RndShift];
  assign limit = RndW'(1) << (SAMPLE_W - 1);
  assign lim   = neg5 ? limit : (limit - 1'b1);
  assign mag_c = (mag_r > lim) ? lim : mag_r;
  assign mag_w = mag_c[SAMPLE_W-1:0];
  assign res6_d = neg5 ? (~mag_w + 1'b1) : mag_w;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      shp3_q  <= shp3_d;
      side3_q <= side_sq;
      p4_q    <= pmul[PMUL_W-1:P_DROP];
      side4_q <= side3_q;
      wp5_q   <= wp5_d;
      dp5_q   <= dp5_d;
      side5_q <= side4_q;
      res6_q  <= res6_d;
    end
  end

  assign shaped_o = res6_q;

endmodule

FILE: rtl/ssat_merge.sv
// Output stage: joins both lane results and the frame tag into one output beat,
// and derives the pipeline advance from the receiver's stall. Depends on ssat_pkg.
module ssat_merge #(
  parameter int unsigned SAMPLE_W = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssat_pkg::beat_tag_t        tag_i,
  input  logic signed [SAMPLE_W-1:0] left_i,
  input  logic signed [SAMPLE_W-1:0] right_i,
  input  logic                       stall_i,
  output logic                       adv_o,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] left_o,
  output logic signed [SAMPLE_W-1:0] right_o,
  output logic                       last_o
);
  import ssat_pkg::*;

  logic                valid_q;
  logic                last_q;
  logic [SAMPLE_W-1:0] left_q, right_q;

  // Advance unless a held beat is stalled
  assign adv_o = !(valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= tag_i.valid;
    end
  end

  // Load the frame payload with the beat
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      last_q  <= tag_i.last;
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;
  assign last_o  = last_q;

endmodule

FILE: rtl/sqrt_soft_saturator_stereo.sv
// Stereo square-root soft saturator: one lane per channel and an output stage.
// Frames enter on a valid/stall channel, registers on a plain write port.
// Depends on ssat_pkg, ssat_lane, ssat_merge.
//
// Usage:
//   Input beat: sample_left_i, sample_right_i, frame_last_i with in_valid_i;
//   the beat is taken when in_valid_i is high and in_stall_o is low.
//   Output beat: shaped_left_o, shaped_right_o, block_end_o with out_valid_o;
//   it is taken when out_valid_o is high and out_stall_i is low.
//   Registers are written with cfg_we_i, cfg_idx_i and cfg_data_i; write them
//   only while no frame is in flight.
// Pipeline and throughput:
//   A frame passes through 37 lane stages, 30 of them the one-bit-per-stage
//   square root, and then the output register.
//   One frame per cycle is accepted while the output keeps moving.
// Reset:
//   Clears all valid bits and loads the register reset values.
// Stall:
//   While an output beat is held by out_stall_i the whole pipeline freezes
//   and in_stall_o is raised; nothing is lost or repeated.
module sqrt_soft_saturator_stereo #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_left_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_right_i,
  input  logic                                frame_last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      shaped_left_o,
  output logic signed [SAMPLE_WIDTH-1:0]      shaped_right_o,
  output logic                                block_end_o,
  input  logic                                cfg_we_i,
  input  logic [ssat_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssat_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ssat_pkg::*;

  cfg_t                    cfg_q;
  beat_tag_t               tag_q [LANE_LAT];
  logic                    adv;
  logic [SAMPLE_WIDTH-1:0] lane_left, lane_right;
  logic [WET_W-1:0]        wet_d;

  // Clamp wet writes at unity
  assign wet_d = (cfg_data_i[WET_W-1:0] > UNITY_Q16) ? UNITY_Q16 : cfg_data_i[WET_W-1:0];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_gain  <= INPUT_GAIN_RST;
      cfg_q.soar_offset <= SOAR_OFFSET_RST;
      cfg_q.output_gain <= OUTPUT_GAIN_RST;
      cfg_q.wet_mix     <= WET_MIX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INPUT_GAIN:  cfg_q.input_gain  <= cfg_data_i[GAIN_W-1:0];
        CFG_SOAR_OFFSET: cfg_q.soar_offset <= cfg_data_i[SOAR_W-1:0];
        CFG_OUTPUT_GAIN: cfg_q.output_gain <= cfg_data_i[GAIN_W-1:0];
        CFG_WET_MIX:     cfg_q.wet_mix     <= wet_d;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !adv;

  // Advance the frame tags alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        tag_q[i] <= '0;
      end
    end else if (adv) begin
      tag_q[0].valid <= in_valid_i;
      tag_q[0].last  <= frame_last_i;
      for (int i = 1; i < LANE_LAT; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  ssat_lane #(
    .SAMPLE_W (SAMPLE_WIDTH)
  ) u_lane_left (
    .clk_i    (clk_i),
    .en_i     (adv),
    .cfg_i    (cfg_q),
    .sample_i (sample_left_i),
    .shaped_o (lane_left)
  );

  ssat_lane #(
    .SAMPLE_W (SAMPLE_WIDTH)
  ) u_lane_right (
    .clk_i    (clk_i),
    .en_i     (adv),
    .cfg_i    (cfg_q),
    .sample_i (sample_right_i),
    .shaped_o (lane_right)
  );

  ssat_merge #(
    .SAMPLE_W (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_q[LANE_LAT-1]),
    .left_i  (lane_left),
    .right_i (lane_right),
    .stall_i (out_stall_i),
    .adv_o   (adv),
    .valid_o (out_valid_o),
    .left_o  (shaped_left_o),
    .right_o (shaped_right_o),
    .last_o  (block_end_o)
  );

endmodule
